FILE: hw/rtl/pma_pkg.sv
// Package: shared types, constants and operation codes for the modular ALU.
package pma_pkg;
	localparam int unsigned ModW = 31;
	localparam int unsigned OpW = 64;
	localparam logic [ModW-1:0] ModReset = 31'd998244353;

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_POW = 3'd4
	} kind_t;

	// Shared unit commands
	typedef enum logic [1:0] {
		UOP_REM = 2'd0,
		UOP_MULMOD = 2'd1
	} uop_t;

	typedef struct packed {
		logic start;
		uop_t op;
		logic [OpW-1:0] num;
		logic [ModW-1:0] mul_b;
		logic [OpW-1:0] den;
	} ucmd_t;

	typedef struct packed {
		logic done;
		logic [OpW-1:0] quo;
		logic [OpW-1:0] rem;
	} ursp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RA,
		ST_RA_W,
		ST_RB,
		ST_RB_W,
		ST_OP,
		ST_MUL_W,
		ST_EU_DIV,
		ST_EU_DIV_W,
		ST_EU_T,
		ST_EU_T_W,
		ST_EU_FIN,
		ST_PW_CHK,
		ST_PW_ACC,
		ST_PW_ACC_W,
		ST_PW_SQ,
		ST_PW_SQ_W,
		ST_FIN_MUL,
		ST_FIN_MUL_W,
		ST_OUT
	} state_t;
endpackage

FILE: hw/rtl/pma_if.sv
// Interfaces: input item, result item and configuration write channels.
interface pma_in_if;
	logic valid;
	logic ready;
	logic [2:0] kind;
	logic signed [63:0] operand_a;
	logic signed [63:0] operand_b;
	modport source (output valid, kind, operand_a, operand_b, input ready);
	modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface pma_out_if;
	logic valid;
	logic ready;
	logic [30:0] result;
	logic error;
	modport source (output valid, result, error, input ready);
	modport sink (input valid, result, error, output ready);
endinterface

interface pma_cfg_if;
	logic valid;
	logic ready;
	logic [30:0] modulus;
	modport source (output valid, modulus, input ready);
	modport sink (input valid, modulus, output ready);
endinterface

FILE: hw/rtl/pma_unit.sv
// Shared unit: radix-2 restoring divider, also used for product modulo reduction.
module pma_unit (
	input logic clk,
	input logic arst_n,
	input pma_pkg::ucmd_t cmd,
	output pma_pkg::ursp_t rsp
);
	logic [63:0] quo_q;
	logic [64:0] rem_q;
	logic [63:0] den_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [64:0] trial;
	logic [61:0] prod;

	assign prod = {31'd0, cmd.num[30:0]} * {31'd0, cmd.mul_b};
	assign trial = {rem_q[63:0], quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= (cmd.op == pma_pkg::UOP_MULMOD) ? {2'd0, prod} : cmd.num;
			rem_q <= '0;
			den_q <= cmd.den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[63:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q[63:0];
endmodule

FILE: hw/rtl/prime_modular_alu.sv
// Top level: modular ALU with sequencer around one shared divide/multiply unit.
// Operands are reduced first; add/sub then finish directly, multiply does one product reduction;
// divide runs Euclid steps (up to ~45 steps) and a final product, stopping early on a zero divisor;
// power does one squaring per exponent bit, plus one multiply per set bit (up to 31 bits).
// One item at a time: no new item is taken until the last result is taken; the shared unit is a 64-step divider.
// Reset: arst_n clears control, modulus returns to 998244353.
module prime_modular_alu (
	input logic clk,
	input logic arst_n,
	pma_in_if.sink in_ch,
	pma_out_if.source out_ch,
	pma_cfg_if.sink cfg
);
	pma_pkg::state_t state_q, state_d;
	pma_pkg::ucmd_t cmd;
	pma_pkg::ursp_t rsp;

	logic [30:0] mod_q;
	logic [2:0] kind_q;
	logic [63:0] opa_q, opb_q;
	logic [30:0] a_q, b_q;
	logic [31:0] r0_q, r1_q;
	logic signed [32:0] t0_q, t1_q;
	logic [31:0] qt_q;
	logic [30:0] acc_q;
	logic [30:0] e_q;
	logic [30:0] res_q;
	logic err_q;

	logic neg_a, neg_b;
	logic [63:0] mag_a, mag_b;
	logic [30:0] modm1;
	logic [31:0] sum_ab;
	logic [31:0] diff_ab;
	logic signed [32:0] tq;
	logic signed [32:0] tnew;
	logic [31:0] rem32;
	logic [30:0] fix_rem;
	logic is_b_red;

	pma_unit u_unit (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	assign neg_a = opa_q[63];
	assign neg_b = opb_q[63];
	assign mag_a = neg_a ? (64'd0 - opa_q) : opa_q;
	assign mag_b = neg_b ? (64'd0 - opb_q) : opb_q;
	assign modm1 = mod_q - 31'd1;
	assign sum_ab = {1'b0, a_q} + {1'b0, b_q};
	assign diff_ab = {1'b0, a_q} + {1'b0, mod_q} - {1'b0, b_q};
	assign rem32 = rsp.rem[31:0];
	assign tq = $signed({1'b0, qt_q});
	assign tnew = t0_q - 33'(tq * t1_q);
	assign is_b_red = (kind_q == pma_pkg::KIND_POW);
	// wrap negative remainder up
	always_comb begin
		if (state_q == pma_pkg::ST_RB_W) begin
			if (neg_b && rem32 != 32'd0)
				fix_rem = 31'((is_b_red ? {1'b0, modm1} : {1'b0, mod_q}) - rem32);
			else
				fix_rem = rem32[30:0];
		end else begin
			fix_rem = (neg_a && rem32 != 32'd0) ? 31'({1'b0, mod_q} - rem32) : rem32[30:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pma_pkg::ST_IDLE: if (in_ch.valid) state_d = pma_pkg::ST_RA;
			pma_pkg::ST_RA: state_d = (mod_q < 31'd2 || kind_q > pma_pkg::KIND_POW)
				? pma_pkg::ST_OUT : pma_pkg::ST_RA_W;
			pma_pkg::ST_RA_W: if (rsp.done) state_d = pma_pkg::ST_RB;
			pma_pkg::ST_RB: state_d = pma_pkg::ST_RB_W;
			pma_pkg::ST_RB_W: if (rsp.done) state_d = pma_pkg::ST_OP;
			pma_pkg::ST_OP: begin
				case (kind_q) inside
					pma_pkg::KIND_ADD, pma_pkg::KIND_SUB: state_d = pma_pkg::ST_OUT;
					pma_pkg::KIND_MUL: state_d = pma_pkg::ST_MUL_W;
					pma_pkg::KIND_DIV: state_d = (b_q == 31'd0) ? pma_pkg::ST_OUT
						: pma_pkg::ST_EU_DIV;
					default: state_d = (a_q == 31'd0) ? pma_pkg::ST_OUT
						: pma_pkg::ST_PW_CHK;
				endcase
			end
			pma_pkg::ST_MUL_W: if (rsp.done) state_d = pma_pkg::ST_OUT;
			pma_pkg::ST_EU_DIV: state_d = (r1_q == 32'd0) ? pma_pkg::ST_EU_FIN
				: pma_pkg::ST_EU_DIV_W;
			pma_pkg::ST_EU_DIV_W: if (rsp.done) state_d = pma_pkg::ST_EU_T;
			pma_pkg::ST_EU_T: state_d = pma_pkg::ST_EU_T_W;
			pma_pkg::ST_EU_T_W: state_d = pma_pkg::ST_EU_DIV;
			pma_pkg::ST_EU_FIN: state_d = (r0_q == 32'd1) ? pma_pkg::ST_FIN_MUL
				: pma_pkg::ST_OUT;
			pma_pkg::ST_PW_CHK: begin
				if (e_q == 31'd0) state_d = pma_pkg::ST_OUT;
				else if (e_q[0]) state_d = pma_pkg::ST_PW_ACC;
				else state_d = pma_pkg::ST_PW_SQ;
			end
			pma_pkg::ST_PW_ACC: state_d = pma_pkg::ST_PW_ACC_W;
			pma_pkg::ST_PW_ACC_W: if (rsp.done) state_d = pma_pkg::ST_PW_SQ;
			pma_pkg::ST_PW_SQ: state_d = pma_pkg::ST_PW_SQ_W;
			pma_pkg::ST_PW_SQ_W: if (rsp.done) state_d = pma_pkg::ST_PW_CHK;
			pma_pkg::ST_FIN_MUL: state_d = pma_pkg::ST_FIN_MUL_W;
			pma_pkg::ST_FIN_MUL_W: if (rsp.done) state_d = pma_pkg::ST_OUT;
			pma_pkg::ST_OUT: if (out_ch.ready) state_d = pma_pkg::ST_IDLE;
			default: state_d = pma_pkg::ST_IDLE;
		endcase
	end

	// unit commands
	always_comb begin
		cmd = '0;
		cmd.den = {33'd0, mod_q};
		unique case (state_q)
			pma_pkg::ST_RA: begin
				cmd.start = (mod_q >= 31'd2 && kind_q <= pma_pkg::KIND_POW);
				cmd.num = mag_a;
			end
			pma_pkg::ST_RB: begin
				cmd.start = 1'b1;
				cmd.num = mag_b;
				if (is_b_red) cmd.den = {33'd0, modm1};
			end
			pma_pkg::ST_OP: begin
				cmd.start = (kind_q == pma_pkg::KIND_MUL);
				cmd.op = pma_pkg::UOP_MULMOD;
				cmd.num = {33'd0, a_q};
				cmd.mul_b = b_q;
			end
			pma_pkg::ST_EU_DIV: begin
				cmd.start = (r1_q != 32'd0);
				cmd.num = {32'd0, r0_q};
				cmd.den = {32'd0, r1_q};
			end
			pma_pkg::ST_PW_ACC: begin
				cmd.start = 1'b1;
				cmd.op = pma_pkg::UOP_MULMOD;
				cmd.num = {33'd0, acc_q};
				cmd.mul_b = a_q;
			end
			pma_pkg::ST_PW_SQ: begin
				cmd.start = 1'b1;
				cmd.op = pma_pkg::UOP_MULMOD;
				cmd.num = {33'd0, a_q};
				cmd.mul_b = a_q;
			end
			pma_pkg::ST_FIN_MUL: begin
				cmd.start = 1'b1;
				cmd.op = pma_pkg::UOP_MULMOD;
				cmd.num = {33'd0, a_q};
				cmd.mul_b = acc_q;
			end
			default: cmd.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pma_pkg::ST_IDLE;
			mod_q <= pma_pkg::ModReset;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) mod_q <= cfg.modulus;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pma_pkg::ST_IDLE: begin
				kind_q <= in_ch.kind;
				opa_q <= in_ch.operand_a;
				opb_q <= in_ch.operand_b;
				res_q <= '0;
				err_q <= 1'b0;
			end
			pma_pkg::ST_RA_W: if (rsp.done) a_q <= fix_rem;
			pma_pkg::ST_RB_W: if (rsp.done) b_q <= fix_rem;
			pma_pkg::ST_OP: begin
				r0_q <= {1'b0, mod_q};
				r1_q <= {1'b0, b_q};
				t0_q <= '0;
				t1_q <= 33'sd1;
				e_q <= b_q;
				acc_q <= 31'd1;
				case (kind_q)
					pma_pkg::KIND_ADD:
						res_q <= (sum_ab >= {1'b0, mod_q}) ? 31'(sum_ab - {1'b0, mod_q})
							: sum_ab[30:0];
					pma_pkg::KIND_SUB:
						res_q <= (diff_ab >= {1'b0, mod_q}) ? 31'(diff_ab - {1'b0, mod_q})
							: diff_ab[30:0];
					pma_pkg::KIND_DIV: err_q <= (b_q == 31'd0);
					default: res_q <= '0;
				endcase
			end
			pma_pkg::ST_MUL_W: if (rsp.done) res_q <= rsp.rem[30:0];
			pma_pkg::ST_EU_DIV_W: if (rsp.done) qt_q <= rsp.quo[31:0];
			// unit holds the remainder of r0 / r1 while idle
			pma_pkg::ST_EU_T: begin
				r0_q <= r1_q;
				r1_q <= rem32;
			end
			pma_pkg::ST_EU_T_W: begin
				t0_q <= t1_q;
				t1_q <= tnew;
			end
			pma_pkg::ST_EU_FIN: begin
				if (r0_q != 32'd1) err_q <= 1'b1;
				acc_q <= t0_q[32] ? 31'(t0_q + $signed({2'b0, mod_q})) : t0_q[30:0];
			end
			pma_pkg::ST_PW_CHK: if (e_q == 31'd0) res_q <= acc_q;
			pma_pkg::ST_PW_ACC_W: if (rsp.done) acc_q <= rsp.rem[30:0];
			pma_pkg::ST_PW_SQ_W: if (rsp.done) begin
				a_q <= rsp.rem[30:0];
				e_q <= e_q >> 1;
			end
			pma_pkg::ST_FIN_MUL_W: if (rsp.done) res_q <= rsp.rem[30:0];
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == pma_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = (state_q == pma_pkg::ST_OUT);
	assign out_ch.result = res_q;
	assign out_ch.error = err_q;

`ifndef ASSERT_OFF
	a_err_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.error |-> kind_q == pma_pkg::KIND_DIV)
		else $error("error flag on non-divide");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.error |-> out_ch.result == 31'd0)
		else $error("error with nonzero result");
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && mod_q >= 31'd2 |-> out_ch.result < mod_q)
		else $error("result not canonical");
	a_no_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pma_pkg::ST_IDLE |-> !cmd.start)
		else $error("unit started while idle");
`endif
endmodule

FILE: dv/prime_modular_alu_test.sv
// Testbench for the modular ALU: random and directed items checked against a local model.
`timescale 1ns / 100ps

module prime_modular_alu_test;
	typedef struct {
		logic [2:0] kind;
		logic [63:0] a;
		logic [63:0] b;
	} alu_item_t;

	typedef struct {
		logic [30:0] result;
		logic error;
	} alu_result_t;

	localparam int WatchdogLimit = 100000;
	localparam int HoldCycles = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pma_in_if in_ch();
	pma_out_if out_ch();
	pma_cfg_if cfg();

	prime_modular_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	alu_item_t pending_items[$];
	alu_result_t expected_results[$];
	logic [63:0] cur_modulus = 64'(pma_pkg::ModReset);
	int mismatches = 0;
	int accepted_items = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;
	bit quiet = 1'b0;

	// canonical residue of a two's complement value
	function automatic logic [63:0] residue(logic [63:0] raw, logic [63:0] m);
		logic [63:0] r;
		if (raw[63]) begin
			r = (64'd0 - raw) % m;
			if (r != 0) r = m - r;
		end else begin
			r = raw % m;
		end
		return r;
	endfunction

	function automatic bit euclid_inverse(logic [63:0] a, logic [63:0] m,
			output logic [63:0] inv);
		longint r0, r1, t0, t1, q, tmp;
		r0 = longint'(m);
		r1 = longint'(a);
		t0 = 0;
		t1 = 1;
		inv = 0;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1;
			r0 = r1;
			r1 = tmp;
			tmp = t0 - q * t1;
			t0 = t1;
			t1 = tmp;
		end
		if (r0 != 1) return 1'b0;
		if (t0 < 0) t0 += longint'(m);
		inv = 64'(t0) % m;
		return 1'b1;
	endfunction

	function automatic logic [63:0] power_mod(logic [63:0] base, logic [63:0] e,
			logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1 % m;
		if (base == 0) return 0;
		while (e != 0) begin
			if (e[0]) acc = (acc * base) % m;
			base = (base * base) % m;
			e >>= 1;
		end
		return acc;
	endfunction

	function automatic alu_result_t alu_predict(alu_item_t it, logic [63:0] m);
		alu_result_t r;
		logic [63:0] ra, rb, inv, v;
		r.result = 0;
		r.error = 1'b0;
		v = 0;
		if (m >= 2) begin
			ra = residue(it.a, m);
			rb = residue(it.b, m);
			case (it.kind)
				pma_pkg::KIND_ADD: v = (ra + rb) % m;
				pma_pkg::KIND_SUB: v = (ra + m - rb) % m;
				pma_pkg::KIND_MUL: v = (ra * rb) % m;
				pma_pkg::KIND_DIV: begin
					if (rb != 0 && euclid_inverse(rb, m, inv)) v = (ra * inv) % m;
					else r.error = 1'b1;
				end
				pma_pkg::KIND_POW: v = power_mod(ra, residue(it.b, m - 1), m);
				default: v = 0;
			endcase
		end
		r.result = v[30:0];
		return r;
	endfunction

	function automatic logic [63:0] pick_operand(logic [63:0] m);
		logic [63:0] v;
		case ($urandom_range(0, 6))
			0, 1: v = {$urandom, $urandom};
			2: v = 64'($signed($urandom_range(0, 40)) - 20);
			3: v = m * $urandom_range(0, 5) + $urandom_range(0, 2) - 1;
			4: v = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
			5: v = 64'(-(m * $urandom_range(1, 4)));
			default: v = 64'($signed($urandom));
		endcase
		return v;
	endfunction

	function automatic alu_item_t make_item(logic [2:0] k, logic [63:0] a, logic [63:0] b);
		alu_item_t it;
		it.kind = k;
		it.a = a;
		it.b = b;
		return it;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.kind = '0;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.modulus = '0;
	end

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				alu_item_t done_item;
				done_item = make_item(in_ch.kind, in_ch.operand_a, in_ch.operand_b);
				expected_results.push_back(alu_predict(done_item, cur_modulus));
				accepted_items++;
				if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					alu_item_t nxt;
					nxt = pending_items.pop_front();
					in_ch.kind <= nxt.kind;
					in_ch.operand_a <= nxt.a;
					in_ch.operand_b <= nxt.b;
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				alu_result_t exp_r;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d error %0d", out_ch.result, out_ch.error);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.result !== out_ch.result || exp_r.error !== out_ch.error) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected result %0d error %0d, got %0d error %0d",
								exp_r.result, exp_r.error, out_ch.result, out_ch.error);
					end
				end
				if (!quiet && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 12);
			end
			// one long hold-off so the block backs up into the input side
			if (!hold_done && accepted_items >= 30) begin
				hold_done = 1'b1;
				hold_cnt = HoldCycles;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WatchdogLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// sample on the falling edge so driver and monitor updates have settled
	task automatic wait_drained();
		while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_modulus(logic [30:0] value);
		@(posedge clk);
		cfg.modulus <= value;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_modulus = 64'(value);
	endtask

	task automatic queue_random(int count, logic [63:0] m);
		logic [2:0] k;
		repeat (count) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: k = pma_pkg::KIND_ADD;
				5, 6, 7, 8: k = pma_pkg::KIND_SUB;
				9, 10, 11, 12: k = pma_pkg::KIND_MUL;
				13, 14, 15: k = pma_pkg::KIND_DIV;
				16, 17, 18: k = pma_pkg::KIND_POW;
				default: k = 3'(int'(pma_pkg::KIND_POW) + $urandom_range(1, 3));
			endcase
			pending_items.push_back(make_item(k, pick_operand(m), pick_operand(m)));
		end
	endtask

	initial begin
		logic [30:0] moduli[9];
		int k;
		moduli = '{31'd2147483647, 31'd2, 31'd3, 31'd0, 31'd1, 31'd15,
			31'd1000000007, 31'd65537, pma_pkg::ModReset};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every kind, special cases at the reset modulus
		for (k = 0; k < 8; k++) begin
			pending_items.push_back(make_item(3'(k), 64'h8000_0000_0000_0000,
				64'h7fff_ffff_ffff_ffff));
			pending_items.push_back(make_item(3'(k), 64'hffff_ffff_ffff_ffff, 64'd12345));
		end
		pending_items.push_back(make_item(pma_pkg::KIND_DIV, 64'd7, 64'd0));
		pending_items.push_back(make_item(pma_pkg::KIND_DIV, 64'd7,
			64'(-64'(pma_pkg::ModReset))));
		pending_items.push_back(make_item(pma_pkg::KIND_POW, 64'd0, 64'd0));
		pending_items.push_back(make_item(pma_pkg::KIND_POW, 64'd5, 64'd0));
		pending_items.push_back(make_item(pma_pkg::KIND_POW, 64'd5,
			64'(pma_pkg::ModReset) - 1));
		pending_items.push_back(make_item(pma_pkg::KIND_POW, 64'd3, 64'hffff_ffff_ffff_fffe));
		pending_items.push_back(make_item(pma_pkg::KIND_SUB, 64'd0, 64'd1));
		queue_random(40, cur_modulus);
		wait_drained();

		foreach (moduli[i]) begin
			write_modulus(moduli[i]);
			if (i == 8) quiet = 1'b1;
			if (moduli[i] == 15) begin
				pending_items.push_back(make_item(pma_pkg::KIND_DIV, 64'd4, 64'd6));
				pending_items.push_back(make_item(pma_pkg::KIND_DIV, 64'd4, 64'd7));
			end
			queue_random(50, cur_modulus);
			wait_drained();
		end

		if (mismatches == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
